// ----- rtl/hkm_pkg.sv -----
package hkm_pkg;

  localparam int MAX_SLOTS         = 6;
  localparam int DEFAULT_KEY_SLOTS = 6;
  localparam int KEY_W             = 8;
  localparam int IDX_W             = 7;
  localparam int MOD_EVENTS        = 3;

  localparam logic [KEY_W-1:0] MOD_SHIFT_MASK = 8'h22;
  localparam logic [KEY_W-1:0] MOD_CTRL_MASK  = 8'h11;
  localparam logic [KEY_W-1:0] MOD_GRAPH_MASK = 8'h44;

  localparam logic [IDX_W-1:0] IDX_SHIFT = 7'd48;
  localparam logic [IDX_W-1:0] IDX_CTRL  = 7'd49;
  localparam logic [IDX_W-1:0] IDX_GRAPH = 7'd50;

  typedef enum logic [1:0] {
    EV_PRESS   = 2'd0,
    EV_RELEASE = 2'd1,
    EV_MENU    = 2'd2
  } event_kind_t;

  typedef enum logic [1:0] {
    NAV_UP     = 2'd0,
    NAV_DOWN   = 2'd1,
    NAV_SELECT = 2'd2,
    NAV_BACK   = 2'd3
  } menu_code_t;

  typedef struct packed {
    event_kind_t      kind;
    logic [IDX_W-1:0] index;
    menu_code_t       code;
  } event_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] index;
  } map_t;

  typedef struct packed {
    logic       hit;
    menu_code_t code;
  } menu_map_t;

  // What one lane found for its old slot (release) and its new slot (press).
  typedef struct packed {
    logic   rel_valid;
    event_t rel;
    logic   prs_valid;
    event_t prs;
  } lane_out_t;

  typedef logic [MAX_SLOTS-1:0][KEY_W-1:0] key_set_t;

  function automatic map_t matrix_of(input logic [KEY_W-1:0] k);
    map_t r;
    r.hit   = 1'b1;
    r.index = '0;
    case (k) inside
      [8'h04:8'h1D]: r.index = IDX_W'(k - 8'h04) + 7'd22;
      [8'h1E:8'h26]: r.index = IDX_W'(k - 8'h1E) + 7'd1;
      [8'h3A:8'h3E]: r.index = IDX_W'(k - 8'h3A) + 7'd53;
      8'h27:         r.index = 7'd0;
      8'h28:         r.index = 7'd63;
      8'h29:         r.index = 7'd58;
      8'h2A:         r.index = 7'd61;
      8'h2B:         r.index = 7'd59;
      8'h2C:         r.index = 7'd64;
      8'h2D:         r.index = 7'd10;
      8'h33:         r.index = 7'd15;
      8'h36:         r.index = 7'd18;
      8'h37:         r.index = 7'd19;
      8'h38:         r.index = 7'd20;
      8'h4C:         r.index = 7'd67;
      8'h4F:         r.index = 7'd71;
      8'h50:         r.index = 7'd68;
      8'h51:         r.index = 7'd70;
      8'h52:         r.index = 7'd69;
      default:       r.hit   = 1'b0;
    endcase
    return r;
  endfunction

  function automatic menu_map_t menu_of(input logic [KEY_W-1:0] k);
    menu_map_t r;
    r.hit  = 1'b1;
    r.code = NAV_UP;
    case (k) inside
      8'h52:               r.code = NAV_UP;
      8'h51:               r.code = NAV_DOWN;
      8'h28, 8'h58, 8'h2C: r.code = NAV_SELECT;
      8'h29, 8'h2A:        r.code = NAV_BACK;
      default:             r.hit  = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/hkm_lane.sv -----
module hkm_lane #(
  parameter int NUM_SLOTS = hkm_pkg::DEFAULT_KEY_SLOTS
) (
  input  logic                       menu_mode,
  input  logic [hkm_pkg::KEY_W-1:0]  old_key,
  input  logic [hkm_pkg::KEY_W-1:0]  new_key,
  input  hkm_pkg::key_set_t          old_keys,
  input  hkm_pkg::key_set_t          new_keys,
  output hkm_pkg::lane_out_t         result
);
  import hkm_pkg::*;

  logic      old_present;
  logic      new_present;
  map_t      old_map;
  map_t      new_map;
  menu_map_t new_menu;

  // A code is present when some active slot of the other report holds it.
  always_comb begin
    old_present = 1'b0;
    new_present = 1'b0;
    for (int j = 0; j < NUM_SLOTS; j++) begin
      if (new_keys[j] == old_key) old_present = 1'b1;
      if (old_keys[j] == new_key) new_present = 1'b1;
    end
  end

  assign old_map  = matrix_of(old_key);
  assign new_map  = matrix_of(new_key);
  assign new_menu = menu_of(new_key);

  always_comb begin
    result.rel_valid = !menu_mode && (old_key != '0) && !old_present && old_map.hit;
    result.rel.kind  = EV_RELEASE;
    result.rel.index = old_map.index;
    result.rel.code  = NAV_UP;

    if (menu_mode) begin
      result.prs_valid = (new_key != '0) && !new_present && new_menu.hit;
      result.prs.kind  = EV_MENU;
      result.prs.index = '0;
      result.prs.code  = new_menu.code;
    end else begin
      result.prs_valid = (new_key != '0) && !new_present && new_map.hit;
      result.prs.kind  = EV_PRESS;
      result.prs.index = new_map.index;
      result.prs.code  = NAV_UP;
    end
  end

endmodule

// ----- rtl/hkm_serializer.sv -----
module hkm_serializer #(
  parameter int NUM_EV = 3 + 2 * hkm_pkg::DEFAULT_KEY_SLOTS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  logic [NUM_EV-1:0]             ev_valid,
  input  hkm_pkg::event_t [NUM_EV-1:0]  ev,
  output logic                          free,
  input  logic                          out_stall,
  output logic                          out_valid,
  output hkm_pkg::event_t               out_ev,
  output logic                          out_last
);
  import hkm_pkg::*;

  logic                     buf_valid;
  logic [NUM_EV-1:0]        mask;
  event_t [NUM_EV-1:0]      evs;
  logic [NUM_EV-1:0]        sel;
  logic [NUM_EV-1:0]        rest;
  logic                     advance;
  event_t                   pick;

  // Lowest pending event goes out first; slot order encodes event order.
  assign sel     = mask & (~mask + 1'b1);
  assign rest    = mask & ~sel;
  assign advance = buf_valid && (!out_valid || !out_stall);
  assign free    = !buf_valid || (advance && (rest == '0));

  always_comb begin
    pick = '0;
    for (int i = 0; i < NUM_EV; i++) begin
      if (sel[i]) pick = evs[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
      mask      <= '0;
    end else if (load && (ev_valid != '0)) begin
      buf_valid <= 1'b1;
      mask      <= ev_valid;
    end else if (advance) begin
      buf_valid <= (rest != '0);
      mask      <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (load) evs <= ev;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_ev   <= pick;
      out_last <= (rest == '0);
    end
  end

endmodule

// ----- rtl/hid_report_to_key_matrix_events.sv -----
// Boot keyboard report to key matrix event converter.
// Input channel (in_valid / in_stall) carries one report: the modifier byte
// and six key slots; only the first KEY_SLOTS slots take part. Each report is
// compared against the previous one by one lane per slot, and the events found
// leave one per cycle on the output channel (out_valid / out_stall) while the
// receiver does not stall, the final event of a report flagged by last. A report
// that changes nothing gives no event and does not occupy the event buffer.
// Config channel (cfg_valid / cfg_ready / cfg_data) writes menu_mode; write it
// only while no report is in flight. cfg_ready is always high.
// The event buffer takes the events of a report at the edge that takes the
// report and hands them one at a time to the output register; the next report
// is taken in the cycle its last event moves to the output register. A report
// gives at most 3 + 2*KEY_SLOTS events.
// Reset clears the stored report, the modifier byte, menu_mode and all valids.
// While the receiver stalls, the output event holds and the buffer fills;
// in_stall rises once a buffered report still has events left.
module hid_report_to_key_matrix_events #(
  parameter int KEY_SLOTS = hkm_pkg::DEFAULT_KEY_SLOTS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [hkm_pkg::KEY_W-1:0]  modifier_bits,
  input  logic [hkm_pkg::KEY_W-1:0]  key_slot_0,
  input  logic [hkm_pkg::KEY_W-1:0]  key_slot_1,
  input  logic [hkm_pkg::KEY_W-1:0]  key_slot_2,
  input  logic [hkm_pkg::KEY_W-1:0]  key_slot_3,
  input  logic [hkm_pkg::KEY_W-1:0]  key_slot_4,
  input  logic [hkm_pkg::KEY_W-1:0]  key_slot_5,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 event_kind,
  output logic [hkm_pkg::IDX_W-1:0]  matrix_index,
  output logic [1:0]                 menu_code,
  output logic                       last
);
  import hkm_pkg::*;

  localparam int NUM_EV = MOD_EVENTS + 2 * KEY_SLOTS;

  logic                  menu_mode;
  key_set_t              prev_keys;
  logic [KEY_W-1:0]      last_mod;
  key_set_t              raw_keys;
  key_set_t              new_keys;
  logic                  accept;
  logic                  free;
  lane_out_t [KEY_SLOTS-1:0] lanes;
  logic [NUM_EV-1:0]     ev_valid;
  event_t [NUM_EV-1:0]   ev;
  event_t                out_ev;
  logic [2:0]            mod_old;
  logic [2:0]            mod_new;
  logic [2:0][IDX_W-1:0] mod_idx;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      menu_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      menu_mode <= cfg_data;
    end
  end

  assign raw_keys = {key_slot_5, key_slot_4, key_slot_3,
                     key_slot_2, key_slot_1, key_slot_0};

  // Unused slots read as empty so they never match and are stored as zero.
  always_comb begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      new_keys[i] = (i < KEY_SLOTS) ? raw_keys[i] : '0;
    end
  end

  assign in_stall = !free;
  assign accept   = in_valid && free;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_keys <= '0;
      last_mod  <= '0;
    end else if (accept) begin
      prev_keys <= new_keys;
      last_mod  <= modifier_bits;
    end
  end

  for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_lane
    hkm_lane #(
      .NUM_SLOTS (KEY_SLOTS)
    ) u_lane (
      .menu_mode (menu_mode),
      .old_key   (prev_keys[g]),
      .new_key   (new_keys[g]),
      .old_keys  (prev_keys),
      .new_keys  (new_keys),
      .result    (lanes[g])
    );
  end

  assign mod_old = {|(last_mod & MOD_GRAPH_MASK), |(last_mod & MOD_CTRL_MASK),
                    |(last_mod & MOD_SHIFT_MASK)};
  assign mod_new = {|(modifier_bits & MOD_GRAPH_MASK),
                    |(modifier_bits & MOD_CTRL_MASK),
                    |(modifier_bits & MOD_SHIFT_MASK)};
  assign mod_idx = {IDX_GRAPH, IDX_CTRL, IDX_SHIFT};

  // Merge: modifier groups first, then releases, then presses.
  always_comb begin
    for (int m = 0; m < MOD_EVENTS; m++) begin
      ev_valid[m]  = !menu_mode && (mod_old[m] != mod_new[m]);
      ev[m].kind   = mod_new[m] ? EV_PRESS : EV_RELEASE;
      ev[m].index  = mod_idx[m];
      ev[m].code   = NAV_UP;
    end
    for (int i = 0; i < KEY_SLOTS; i++) begin
      ev_valid[MOD_EVENTS + i]             = lanes[i].rel_valid;
      ev[MOD_EVENTS + i]                   = lanes[i].rel;
      ev_valid[MOD_EVENTS + KEY_SLOTS + i] = lanes[i].prs_valid;
      ev[MOD_EVENTS + KEY_SLOTS + i]       = lanes[i].prs;
    end
  end

  hkm_serializer #(
    .NUM_EV (NUM_EV)
  ) u_serializer (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .ev_valid  (ev_valid),
    .ev        (ev),
    .free      (free),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_ev    (out_ev),
    .out_last  (last)
  );

  assign event_kind   = out_ev.kind;
  assign matrix_index = out_ev.index;
  assign menu_code    = out_ev.code;

endmodule

// ----- rtl/hkm_checker.sv -----
module hkm_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [1:0]                 event_kind,
  input logic [hkm_pkg::IDX_W-1:0]  matrix_index,
  input logic [1:0]                 menu_code,
  input logic                       last
);
  import hkm_pkg::*;

  // Hold a stalled event.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(event_kind) &&
      $stable(matrix_index) && $stable(menu_code) && $stable(last))
    else $error("stalled event changed");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("event valid right after reset");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> event_kind == EV_PRESS || event_kind == EV_RELEASE ||
      event_kind == EV_MENU)
    else $error("unused event kind");

  a_menu_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_kind == EV_MENU) |-> matrix_index == '0)
    else $error("menu event with matrix index");

  a_key_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_kind == EV_PRESS || event_kind == EV_RELEASE) |->
      menu_code == NAV_UP && matrix_index <= 7'd71)
    else $error("key event with bad fields");

endmodule

bind hid_report_to_key_matrix_events hkm_checker u_hkm_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .event_kind   (event_kind),
  .matrix_index (matrix_index),
  .menu_code    (menu_code),
  .last         (last)
);

// ----- test/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import hkm_pkg::*;

  localparam int SLOTS = DEFAULT_KEY_SLOTS;
  localparam int DRAIN_SLACK = 6;
  localparam logic [7:0] NAV_POOL [8] = '{8'h52, 8'h51, 8'h28, 8'h58, 8'h2C, 8'h29, 8'h2A, 8'h4F};

  typedef struct {
    event_kind_t      kind;
    logic [IDX_W-1:0] index;
    menu_code_t       code;
    logic             last;
  } key_event_t;

  logic             clk;
  logic             rst = 1'b1;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic             cfg_data = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [KEY_W-1:0] modifier_bits = '0;
  logic [KEY_W-1:0] key_slot_0 = '0;
  logic [KEY_W-1:0] key_slot_1 = '0;
  logic [KEY_W-1:0] key_slot_2 = '0;
  logic [KEY_W-1:0] key_slot_3 = '0;
  logic [KEY_W-1:0] key_slot_4 = '0;
  logic [KEY_W-1:0] key_slot_5 = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [1:0]       event_kind;
  logic [IDX_W-1:0] matrix_index;
  logic [1:0]       menu_code;
  logic             last;

  // Predictor state: last report seen and the mode register.
  key_set_t         seen_keys = '0;
  logic [KEY_W-1:0] seen_mod = '0;
  logic             menu_on = 1'b0;

  key_event_t       pending_events[$];

  // Stimulus state: the keyboard as the random part holds it.
  key_set_t         held_keys = '0;
  logic [KEY_W-1:0] held_mod = '0;

  int fail_count = 0;
  int reports_sent = 0;
  int menu_reports = 0;
  int events_checked = 0;
  int mode_writes = 0;
  int burst_left = 0;
  int max_gap = 0;
  int stall_pct = 0;
  int stall_left = 0;
  bit stall_hold = 0;

  hid_report_to_key_matrix_events dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .modifier_bits(modifier_bits),
    .key_slot_0   (key_slot_0),
    .key_slot_1   (key_slot_1),
    .key_slot_2   (key_slot_2),
    .key_slot_3   (key_slot_3),
    .key_slot_4   (key_slot_4),
    .key_slot_5   (key_slot_5),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_kind   (event_kind),
    .matrix_index (matrix_index),
    .menu_code    (menu_code),
    .last         (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  // Matrix position of a HID usage, -1 when the key has no place on the matrix.
  function automatic int hid_to_matrix(input logic [7:0] k);
    if (k >= 8'h04 && k <= 8'h1D) return 22 + int'(k - 8'h04);
    if (k >= 8'h1E && k <= 8'h26) return 1 + int'(k - 8'h1E);
    if (k >= 8'h3A && k <= 8'h3E) return 53 + int'(k - 8'h3A);
    case (k)
      8'h27: return 0;
      8'h28: return 63;
      8'h29: return 58;
      8'h2A: return 61;
      8'h2B: return 59;
      8'h2C: return 64;
      8'h2D: return 10;
      8'h33: return 15;
      8'h36: return 18;
      8'h37: return 19;
      8'h38: return 20;
      8'h4C: return 67;
      8'h4F: return 71;
      8'h50: return 68;
      8'h51: return 70;
      8'h52: return 69;
      default: return -1;
    endcase
  endfunction

  function automatic int hid_to_nav(input logic [7:0] k);
    case (k)
      8'h52: return int'(NAV_UP);
      8'h51: return int'(NAV_DOWN);
      8'h28, 8'h58, 8'h2C: return int'(NAV_SELECT);
      8'h29, 8'h2A: return int'(NAV_BACK);
      default: return -1;
    endcase
  endfunction

  function automatic bit held_in(input key_set_t set, input logic [7:0] k);
    if (k == 8'h00) return 1'b0;
    for (int i = 0; i < SLOTS; i++)
      if (set[i] == k) return 1'b1;
    return 1'b0;
  endfunction

  function automatic key_event_t make_event(input event_kind_t kind, input int index,
                                            input menu_code_t code);
    key_event_t ev;
    ev.kind  = kind;
    ev.index = IDX_W'(index);
    ev.code  = code;
    ev.last  = 1'b0;
    return ev;
  endfunction

  function automatic key_set_t make_slots(input logic [7:0] s0, s1, s2, s3, s4, s5);
    key_set_t k;
    k[0] = s0;
    k[1] = s1;
    k[2] = s2;
    k[3] = s3;
    k[4] = s4;
    k[5] = s5;
    return k;
  endfunction

  // Work out the events one report causes and queue them behind earlier ones.
  function automatic void predict_report(input logic [7:0] mod, input key_set_t keys);
    key_event_t       evs[$];
    logic [KEY_W-1:0] masks [3];
    int               idx [3];
    int               code;
    bit               was_on;
    bit               now_on;
    masks = '{MOD_SHIFT_MASK, MOD_CTRL_MASK, MOD_GRAPH_MASK};
    idx   = '{int'(IDX_SHIFT), int'(IDX_CTRL), int'(IDX_GRAPH)};
    if (menu_on) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (keys[i] != 8'h00 && !held_in(seen_keys, keys[i])) begin
          code = hid_to_nav(keys[i]);
          if (code >= 0) evs.push_back(make_event(EV_MENU, 0, menu_code_t'(code)));
        end
      end
    end else begin
      for (int g = 0; g < 3; g++) begin
        was_on = |(seen_mod & masks[g]);
        now_on = |(mod & masks[g]);
        if (now_on && !was_on) evs.push_back(make_event(EV_PRESS, idx[g], NAV_UP));
        else if (!now_on && was_on) evs.push_back(make_event(EV_RELEASE, idx[g], NAV_UP));
      end
      for (int i = 0; i < SLOTS; i++) begin
        if (seen_keys[i] != 8'h00 && !held_in(keys, seen_keys[i])) begin
          code = hid_to_matrix(seen_keys[i]);
          if (code >= 0) evs.push_back(make_event(EV_RELEASE, code, NAV_UP));
        end
      end
      for (int i = 0; i < SLOTS; i++) begin
        if (keys[i] != 8'h00 && !held_in(seen_keys, keys[i])) begin
          code = hid_to_matrix(keys[i]);
          if (code >= 0) evs.push_back(make_event(EV_PRESS, code, NAV_UP));
        end
      end
    end
    if (evs.size() > 0) evs[evs.size()-1].last = 1'b1;
    foreach (evs[i]) pending_events.push_back(evs[i]);
    for (int i = 0; i < MAX_SLOTS; i++) seen_keys[i] = (i < SLOTS) ? keys[i] : 8'h00;
    seen_mod = mod;
  endfunction

  // Receiver: stall in runs of random length at a density set per test.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_left = $urandom_range(1, 8);
        stall_hold = ($urandom_range(0, 99) < stall_pct);
      end
      stall_left--;
      out_stall <= stall_hold;
    end
  end

  always @(posedge clk) begin : check_events
    key_event_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        $error("unexpected event: kind %0d index %0d code %0d last %0d",
               event_kind, matrix_index, menu_code, last);
        fail_count++;
      end else begin
        want = pending_events.pop_front();
        events_checked++;
        if (event_kind !== want.kind) begin
          $error("event_kind: expected %0d, got %0d", want.kind, event_kind);
          fail_count++;
        end
        if (matrix_index !== want.index) begin
          $error("matrix_index: expected %0d, got %0d", want.index, matrix_index);
          fail_count++;
        end
        if (menu_code !== want.code) begin
          $error("menu_code: expected %0d, got %0d", want.code, menu_code);
          fail_count++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last);
          fail_count++;
        end
      end
    end
  end

  // Send one report; the request stays up after acceptance until the next
  // call or a drain decides what to drive.
  task automatic send_report(input logic [7:0] mod, input key_set_t keys);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (max_gap > 0) gap = $urandom_range(1, max_gap);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    modifier_bits <= mod;
    key_slot_0    <= keys[0];
    key_slot_1    <= keys[1];
    key_slot_2    <= keys[2];
    key_slot_3    <= keys[3];
    key_slot_4    <= keys[4];
    key_slot_5    <= keys[5];
    do @(posedge clk); while (in_stall);
    predict_report(mod, keys);
    reports_sent++;
    if (menu_on) menu_reports++;
  endtask

  // Drop the request, then hold until every queued event has been seen.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic set_menu_mode(input logic mode);
    wait_for_drain();
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    menu_on = mode;
    mode_writes++;
  endtask

  task automatic random_reports(input int count);
    key_set_t         keys;
    logic [KEY_W-1:0] mod;
    logic [KEY_W-1:0] tmp;
    int               r;
    int               a;
    int               b;
    for (int n = 0; n < count; n++) begin
      keys = held_keys;
      mod  = held_mod;
      r = $urandom_range(0, 99);
      if (r < 12) begin
        // Noise: any byte in any field.
        mod = 8'($urandom_range(0, 255));
        for (int i = 0; i < MAX_SLOTS; i++)
          keys[i] = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
      end else if (r < 18) begin
        // Same keys in another slot order.
        a = $urandom_range(0, SLOTS - 1);
        b = $urandom_range(0, SLOTS - 1);
        tmp = keys[a];
        keys[a] = keys[b];
        keys[b] = tmp;
      end else begin
        if ($urandom_range(0, 99) < 40) mod = mod ^ (8'h01 << $urandom_range(0, 7));
        for (int i = 0; i < SLOTS; i++) begin
          if ($urandom_range(0, 99) < 30) begin
            if ($urandom_range(0, 2) == 0) begin
              keys[i] = 8'h00;
            end else begin
              case ($urandom_range(0, 4))
                0: keys[i] = 8'($urandom_range(8'h04, 8'h1D));
                1: keys[i] = 8'($urandom_range(8'h1E, 8'h2D));
                2: keys[i] = 8'($urandom_range(8'h33, 8'h3E));
                3: keys[i] = NAV_POOL[3'($urandom_range(0, 7))];
                default: keys[i] = 8'($urandom_range(8'h40, 8'hFF));
              endcase
            end
          end
        end
      end
      send_report(mod, keys);
      held_keys = keys;
      held_mod  = mod;
    end
  endtask

  task automatic test_key_matrix_directed();
    max_gap   = 3;
    stall_pct = 30;
    send_report(8'h00, make_slots(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(8'hFF, make_slots(8'h04, 8'h1D, 8'h1E, 8'h26, 8'h3A, 8'h3E));
    // Modifier bits 3 and 7 alone: all three groups let go.
    send_report(8'h88, make_slots(8'h3E, 8'h3A, 8'h26, 8'h1E, 8'h1D, 8'h04));
    // Full swap of keys and modifiers: the longest burst of events.
    send_report(8'h77, make_slots(8'h27, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C));
    send_report(8'h77, make_slots(8'h27, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C));
    send_report(8'h00, make_slots(8'h2D, 8'h33, 8'h36, 8'h37, 8'h38, 8'h4C));
    send_report(8'h02, make_slots(8'h4F, 8'h50, 8'h51, 8'h52, 8'h00, 8'h00));
    // Other shift bit keeps the group on; codes off the matrix stay silent.
    send_report(8'h20, make_slots(8'hFF, 8'h01, 8'h2E, 8'h80, 8'h58, 8'h00));
    send_report(8'h10, make_slots(8'h05, 8'h05, 8'h05, 8'h00, 8'h00, 8'h00));
    send_report(8'h10, make_slots(8'h00, 8'h05, 8'h00, 8'h00, 8'h00, 8'h05));
    send_report(8'h40, make_slots(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(8'h00, make_slots(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    held_keys = seen_keys;
    held_mod  = seen_mod;
  endtask

  task automatic test_menu_directed();
    set_menu_mode(1'b1);
    send_report(8'hFF, make_slots(8'h52, 8'h51, 8'h28, 8'h58, 8'h2C, 8'h29));
    send_report(8'h00, make_slots(8'h2A, 8'h52, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(8'h00, make_slots(8'h04, 8'h1E, 8'h27, 8'hFF, 8'h00, 8'h00));
    send_report(8'h44, make_slots(8'h52, 8'h52, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(8'h00, make_slots(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    held_keys = seen_keys;
    held_mod  = seen_mod;
  endtask

  task automatic test_random_key_matrix();
    set_menu_mode(1'b0);
    max_gap   = 6;
    stall_pct = 40;
    random_reports(140);
  endtask

  task automatic test_random_menu();
    set_menu_mode(1'b1);
    max_gap   = 4;
    stall_pct = 20;
    random_reports(70);
  endtask

  task automatic test_mode_switching();
    max_gap   = 5;
    stall_pct = 50;
    for (int p = 0; p < 6; p++) begin
      set_menu_mode(p[0] ? 1'b0 : 1'b1);
      random_reports(10);
    end
  endtask

  task automatic test_drain_pause();
    set_menu_mode(1'b0);
    max_gap   = 0;
    stall_pct = 0;
    random_reports(10);
    wait_for_drain();
    stall_pct = 85;
    random_reports(10);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_key_matrix_directed();
    test_menu_directed();
    test_random_key_matrix();
    test_random_menu();
    test_mode_switching();
    test_drain_pause();
    wait_for_drain();
    repeat (20) @(posedge clk);
    if (pending_events.size() != 0) begin
      $error("%0d events never arrived", pending_events.size());
      fail_count++;
    end
    $display("Ran %0d reports (%0d in menu mode) over %0d mode writes.",
             reports_sent, menu_reports, mode_writes);
    $display("Checked %0d events; %0d mismatches.", events_checked, fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
